// ===== design/rmst_pkg.sv =====
// Package: shared constants, types and commands for the range-minimum sparse table.
`timescale 1ns / 1ps
package rmst_pkg;
  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned Levels    = 11;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned PosBits   = 11;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] value;
    logic        is_last;
    logic [10:0] left;
    logic [10:0] right;
  } in_word_t;

  typedef struct packed {
    logic [31:0] min_value;
    logic [10:0] min_position;
    logic        query_error;
  } out_word_t;
endpackage

// ===== design/rmst_if.sv =====
// Interface: valid/ready channel carrying one word.
`timescale 1ns / 1ps
interface rmst_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ===== design/rmst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rmst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/range_minimum_sparse_table.sv =====
// Range-minimum query engine over a sparse table held in two RAMs; sequencer and top level.
// One RAM holds the loaded values, the other the index of the minimum of every power-of-two
// window. A load writes its value into the value RAM as it is taken, if there is room. The
// load marked last starts a build: it fills level 0, then on each higher level handles each
// entry in turn (two table reads, two value reads, compare and write); no word is taken
// during it. A query passes through the states S_QA, S_QB and S_QV before its result sits
// in the output register; a query with bad bounds, or one before a build, answers the next
// cycle with query_error set. The next word is taken in the cycle the pending result leaves.
// On equal values the leftmost position wins.
`timescale 1ns / 1ps
module range_minimum_sparse_table #(
  parameter int unsigned MAX_ITEMS  = rmst_pkg::MaxItems,
  parameter int unsigned LEVELS     = rmst_pkg::Levels,
  parameter int unsigned VALUE_BITS = rmst_pkg::ValueBits
) (
  input logic clk_i,
  input logic rst_ni,
  rmst_if.sink   in_i,
  rmst_if.source out_o
);
  localparam int unsigned PW  = rmst_pkg::PosBits;
  localparam int unsigned AW  = $clog2(MAX_ITEMS);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned QW  = ((CW > PW) ? CW : PW) + 1;
  localparam int unsigned LW  = $clog2(LEVELS);
  localparam int unsigned TD  = LEVELS << AW;
  localparam int unsigned TAW = $clog2(TD);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_B0   = 9'b000000010,
    S_BA   = 9'b000000100,
    S_BB   = 9'b000001000,
    S_BV   = 9'b000010000,
    S_BW   = 9'b000100000,
    S_QA   = 9'b001000000,
    S_QB   = 9'b010000000,
    S_QV   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ready_q, ready_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] ia_q, ia_d, ib_q, ib_d, qr_q, qr_d;
  logic [VALUE_BITS-1:0] va_q, va_d;
  logic          ovalid_q, ovalid_d;
  rmst_pkg::out_word_t oword_q, oword_d;

  logic          ewe, twe;
  logic [AW-1:0] ewa, era;
  logic [VALUE_BITS-1:0] ewd, erd;
  logic [TAW-1:0] twa, tra;
  logic [AW-1:0]  twd, trd;

  rmst_pkg::in_word_t iw;
  logic [63:0]   in_wide;
  logic          in_rdy;
  logic          acc;
  logic [QW-1:0] ql, qr, qcnt, qlen, qastart, qbstart;
  logic [31:0]   qk;
  logic          qbad;
  logic [SW-1:0] span, half, reach, hsum;
  logic [CW-1:0] load_base;
  logic          load_room;

  rmst_ram #(.Width(VALUE_BITS), .Depth(MAX_ITEMS)) u_elem (
    .clk_i, .we_i(ewe), .waddr_i(ewa), .wdata_i(ewd), .raddr_i(era), .rdata_o(erd));
  rmst_ram #(.Width(AW), .Depth(TD)) u_tab (
    .clk_i, .we_i(twe), .waddr_i(twa), .wdata_i(twd), .raddr_i(tra), .rdata_o(trd));

  function automatic logic [TAW-1:0] taddr(logic [LW-1:0] l, logic [AW-1:0] i);
    logic [LW+AW-1:0] t;
    t = {l, i};
    return t[TAW-1:0];
  endfunction

  function automatic logic [31:0] out_value(logic [VALUE_BITS-1:0] v);
    logic [63:0] w;
    w = '0;
    w[VALUE_BITS-1:0] = v;
    return w[31:0];
  endfunction

  function automatic logic [PW-1:0] out_pos(logic [AW-1:0] i);
    logic [31:0] p;
    p = 32'(i) + 32'd1;
    return p[PW-1:0];
  endfunction

  assign iw = in_i.word;
  assign in_wide = {32'd0, iw.value};
  assign in_rdy = (state_q == S_IDLE) && (!ovalid_q || out_o.ready);
  assign in_i.ready = in_rdy;
  assign acc = in_i.valid && in_rdy;
  assign out_o.valid = ovalid_q;
  assign out_o.word = oword_q;

  // query level: floor(log2(len))
  assign ql = QW'(iw.left);
  assign qr = QW'(iw.right);
  assign qcnt = QW'(count_q);
  assign qlen = qr - ql + QW'(1);
  always_comb begin
    qk = '0;
    for (int b = 0; b < QW; b++) if (qlen[b]) qk = 32'(b);
  end
  assign qbad = !ready_q || ql == '0 || qr < ql || qr > qcnt || qk >= LEVELS;
  assign qastart = ql - QW'(1);
  assign qbstart = qr - (QW'(1) << qk);

  assign span = SW'(1) << lvl_q;
  assign half = span >> 1;
  assign reach = SW'(idx_q) + span;
  assign hsum = SW'(idx_q) + half;

  assign load_base = ready_q ? '0 : count_q;
  assign load_room = load_base < CW'(MAX_ITEMS);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ready_d = ready_q;
    lvl_d = lvl_q;
    idx_d = idx_q;
    ia_d = ia_q;
    ib_d = ib_q;
    qr_d = qr_q;
    va_d = va_q;
    ovalid_d = ovalid_q;
    oword_d = oword_q;
    ewe = 1'b0;
    ewa = load_base[AW-1:0];
    ewd = in_wide[VALUE_BITS-1:0];
    era = ia_q;
    twe = 1'b0;
    twa = taddr(lvl_q, idx_q[AW-1:0]);
    twd = idx_q[AW-1:0];
    tra = taddr(qk[LW-1:0], qastart[AW-1:0]);
    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc && iw.cmd == rmst_pkg::CmdLoad) begin
          ready_d = 1'b0;
          ewe = load_room;
          count_d = load_room ? load_base + CW'(1) : load_base;
          if (iw.is_last) begin
            idx_d = '0;
            lvl_d = '0;
            state_d = S_B0;
          end
        end else if (acc && qbad) begin
          ovalid_d = 1'b1;
          oword_d = '{min_value: '0, min_position: '0, query_error: 1'b1};
        end else if (acc) begin
          lvl_d = qk[LW-1:0];
          qr_d = qbstart[AW-1:0];
          state_d = S_QA;
        end
      end
      S_B0: begin
        if (idx_q == count_q) begin
          idx_d = '0;
          lvl_d = LW'(1);
          if (count_q >= CW'(2)) begin
            state_d = S_BA;
          end else begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          twe = 1'b1;
          idx_d = idx_q + CW'(1);
        end
      end
      S_BA: begin
        if (reach > SW'(count_q)) begin
          idx_d = '0;
          lvl_d = lvl_q + LW'(1);
          if (32'(lvl_q) + 32'd1 >= LEVELS || (span << 1) > SW'(count_q)) begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          tra = taddr(lvl_q - LW'(1), idx_q[AW-1:0]);
          state_d = S_BB;
        end
      end
      S_BB: begin
        ia_d = trd;
        era = trd;
        tra = taddr(lvl_q - LW'(1), hsum[AW-1:0]);
        state_d = S_BV;
      end
      S_BV: begin
        ib_d = trd;
        era = trd;
        va_d = erd;
        state_d = S_BW;
      end
      S_BW: begin
        twe = 1'b1;
        twd = ($signed(va_q) <= $signed(erd)) ? ia_q : ib_q;
        idx_d = idx_q + CW'(1);
        state_d = S_BA;
      end
      S_QA: begin
        ia_d = trd;
        era = trd;
        tra = taddr(lvl_q, qr_q);
        state_d = S_QB;
      end
      S_QB: begin
        ib_d = trd;
        era = trd;
        va_d = erd;
        state_d = S_QV;
      end
      S_QV: begin
        ovalid_d = 1'b1;
        oword_d.query_error = 1'b0;
        if ($signed(va_q) <= $signed(erd)) begin
          oword_d.min_value = out_value(va_q);
          oword_d.min_position = out_pos(ia_q);
        end else begin
          oword_d.min_value = out_value(erd);
          oword_d.min_position = out_pos(ib_q);
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ready_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ready_q <= ready_d;
      ovalid_q <= ovalid_d;
    end
  end
  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    idx_q <= idx_d;
    ia_q <= ia_d;
    ib_q <= ib_d;
    qr_q <= qr_d;
    va_q <= va_d;
    oword_q <= oword_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> state_q == S_IDLE)
    else $error("result pending outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_ITEMS))
    else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready) |=> ovalid_q && $stable(oword_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
endmodule
